@@ hw/rtl/fngc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fngc_pkg
// Shared types, constants and the arctangent table of the filtered nearest
// great-circle search.
// ----------------------------------------------------------------------------
package fngc_pkg;

  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int LANG_W   = 3;
  localparam int IDX_W    = 10;
  localparam int DIST_W   = 25;
  localparam int CQ_W     = 36;
  localparam int ZW       = 34;
  localparam int VW       = 33;
  localparam int SQ_VW    = 62;
  localparam int SQ_RW    = 31;
  localparam int SQ_STEPS = 31;
  localparam int PROD_W   = 65;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  localparam logic [32:0]              RAD_MUL   = 33'd8048910509;
  localparam logic signed [CQ_W-1:0]   CORDIC_X0 = 36'sd652032874;
  localparam logic [31:0]              TWO_R     = 32'd12742000;
  localparam logic [DIST_W-1:0]        DIST_SAT  = 25'd20037509;
  localparam logic [DIST_W-1:0]        DIST_ONES = '1;
  localparam logic signed [LAT_W-1:0]  LAT_LIMIT = 31'sd900000000;
  localparam logic signed [33:0]       LON_HALF  = 34'sd1800000000;
  localparam logic signed [33:0]       LON_FULL  = 34'sd3600000000;
  localparam logic [30:0]              Q_ONE     = 31'h40000000;
  localparam logic signed [34:0]       Q_ONE_S   = 35'sd1073741824;
  localparam logic [SQ_VW-1:0]         SQ_TOP    = SQ_VW'(1) << 60;

  localparam logic [CFG_AW-1:0] REG_QUERY_LAT = 2'd0;
  localparam logic [CFG_AW-1:0] REG_QUERY_LON = 2'd1;
  localparam logic [CFG_AW-1:0] REG_REQ_LANG  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_REQ_INS   = 2'd3;

  typedef struct packed {
    logic signed [LAT_W-1:0] cand_lat;
    logic signed [LON_W-1:0] cand_lon;
    logic [LANG_W-1:0]       cand_language;
    logic                    cand_insurance;
    logic                    last_item;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist_m;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_PREP, OP_RAD, OP_RADW, OP_RSTORE, OP_MUL, OP_MULW,
    OP_SQS, OP_VES, OP_DIST, OP_DISTW, OP_UPD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic cbusy;
    logic sbusy;
  } stat_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [5:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      6'd0:  v = 34'sh3243F6A8;
      6'd1:  v = 34'sh1DAC6705;
      6'd2:  v = 34'sh0FADBAFC;
      6'd3:  v = 34'sh07F56EA6;
      6'd4:  v = 34'sh03FEAB76;
      6'd5:  v = 34'sh01FFD55B;
      6'd6:  v = 34'sh00FFFAAA;
      6'd7:  v = 34'sh007FFF55;
      6'd8:  v = 34'sh003FFFEA;
      6'd9:  v = 34'sh001FFFFD;
      6'd10: v = 34'sh000FFFFF;
      6'd11: v = 34'sh0007FFFF;
      6'd12: v = 34'sh0003FFFF;
      6'd13: v = 34'sh0001FFFF;
      6'd14: v = 34'sh0000FFFF;
      6'd15: v = 34'sh00007FFF;
      6'd16: v = 34'sh00003FFF;
      6'd17: v = 34'sh00001FFF;
      6'd18: v = 34'sh00000FFF;
      6'd19: v = 34'sh000007FF;
      6'd20: v = 34'sh000003FF;
      6'd21: v = 34'sh000001FF;
      6'd22: v = 34'sh000000FF;
      6'd23: v = 34'sh0000007F;
      6'd24: v = 34'sh0000003F;
      6'd25: v = 34'sh0000001F;
      6'd26: v = 34'sh0000000F;
      6'd27: v = 34'sh00000008;
      6'd28: v = 34'sh00000004;
      6'd29: v = 34'sh00000002;
      6'd30: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/filtered_nearest_great_circle_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_nearest_great_circle_top
// Nearest matching candidate by haversine distance to a configured query.
//
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (query latitude,
// query longitude, required language, required insurance); write only while
// busy is low. Input: a candidate transfer happens on a clock edge with start
// high and busy low. Each candidate keeps the block busy while it is
// processed, so a new candidate is taken only after busy falls; the
// iterative CORDIC unit, used four times for sine/cosine and once for the
// arctangent, takes most of that time.
// Candidates past MAX_CANDIDATES in a set skip the distance and go straight
// to the update. Output: the candidate marked last_item yields one result on
// out_data with out_valid high for one cycle, in the cycle busy falls; the
// receiver cannot stall, so it must take it then. Other candidates give no
// result. After a result the search state clears; registers are kept.
// Reset (rst_n low, synchronous) restores register defaults and clears the
// search.
// ----------------------------------------------------------------------------
module filtered_nearest_great_circle_top import fngc_pkg::*; #(
  parameter int MAX_CANDIDATES = 1024,
  parameter int CORDIC_STEPS   = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data
);

  cmd_t  cmd;
  stat_t stat;

  fngc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fngc_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result outside the end of a busy period");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.best_idx == '0 &&
      out_data.best_dist_m == '0)
    else $error("result without match carries data");

  a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.best_dist_m <= DIST_SAT)
    else $error("distance beyond saturation");
`endif

endmodule

@@ hw/rtl/fngc_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fngc_cordic
// Iterative CORDIC, one step per cycle, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module fngc_cordic import fngc_pkg::*; #(
  parameter int STEPS = 30
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   vec_mode,
  input  logic signed [CQ_W-1:0] x_in,
  input  logic signed [CQ_W-1:0] y_in,
  input  logic signed [ZW-1:0]   z_in,
  output logic                   busy,
  output logic signed [CQ_W-1:0] x_out,
  output logic signed [CQ_W-1:0] y_out,
  output logic signed [ZW-1:0]   z_out
);

  localparam int CW = $clog2(STEPS);

  logic                   active_r, active_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   mode_r;
  logic signed [CQ_W-1:0] x_r, y_r, dx, dy;
  logic signed [ZW-1:0]   z_r, ang;
  logic                   use_a;

  assign dx    = y_r >>> cnt_r;
  assign dy    = x_r >>> cnt_r;
  assign ang   = atan_tab(6'(cnt_r));
  assign use_a = mode_r ? !(y_r > 0) : (z_r >= 0);

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= vec_mode;
      x_r    <= x_in;
      y_r    <= y_in;
      z_r    <= z_in;
    end else if (active_r) begin
      if (use_a) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
    end
  end

  assign busy  = active_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

@@ hw/rtl/fngc_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fngc_isqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fngc_isqrt import fngc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_VW-1:0]  v_in,
  output logic              busy,
  output logic [SQ_RW-1:0]  root
);

  logic             active_r, active_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [SQ_VW-1:0] rem_r, r_r, bit_r, trial;

  assign trial = r_r + bit_r;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 5'(SQ_STEPS - 1)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= v_in;
      r_r   <= '0;
      bit_r <= SQ_TOP;
    end else if (active_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        r_r   <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = active_r;
  assign root = r_r[SQ_RW-1:0];

endmodule

@@ hw/rtl/fngc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fngc_dp
// Datapath: configuration registers, angle conversion, shared multiplier,
// CORDIC and square root units, and the running minimum.
// ----------------------------------------------------------------------------
module fngc_dp import fngc_pkg::*; #(
  parameter int MAX_CANDIDATES = 1024,
  parameter int CORDIC_STEPS   = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  in_t               in_data,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              out_valid,
  output out_t              out_data
);

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

  logic signed [LAT_W-1:0] qlat_r, lat1_r, lat2_r, lat1_c, lat2_c;
  logic signed [LON_W-1:0] qlon_r, lon2_r;
  logic [LANG_W-1:0]       req_lang_r;
  logic                    req_ins_r;
  logic                    match_r, last_r, skip_r;

  logic signed [31:0]      dlat_r, dlat_w, dlon_r;
  logic signed [33:0]      dl0, dl1;

  logic signed [32:0]      rad_v, mp, mq;
  logic [32:0]             mul_a, mp_abs, mq_abs;
  logic [31:0]             mul_b;
  logic                    mul_neg;
  logic [PROD_W-1:0]       mul_p, prod_r, rnd32, rnd33, rnd30;
  logic                    neg_r, half_r;
  logic [31:0]             rmag;
  logic signed [ZW-1:0]    theta;
  logic signed [33:0]      mr;
  logic signed [34:0]      asum;

  logic signed [VW-1:0]    c1_r, c2_r, shlat_r, shlon_r, t_r, u_r;
  logic signed [33:0]      a_r;
  logic [30:0]             amag;

  logic                    c_start, c_vec;
  logic signed [CQ_W-1:0]  c_xin, c_yin, c_x, c_y;
  logic signed [ZW-1:0]    c_zin, c_z;
  logic                    c_busy, s0_busy, s1_busy, s_start;
  logic [SQ_RW-1:0]        sa, sb;
  logic [32:0]             zc;
  logic [DIST_W-1:0]       dist_r;

  logic [CNT_W-1:0]        count_r, count_nxt, min_idx_r, min_idx_nxt;
  logic [DIST_W-1:0]       min_dist_r, min_dist_nxt;
  logic                    any_r, any_nxt, hit;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlat_r     <= 31'sd423601000;
      qlon_r     <= -32'sd710589000;
      req_lang_r <= '0;
      req_ins_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUERY_LAT: qlat_r     <= cfg_wdata[LAT_W-1:0];
        REG_QUERY_LON: qlon_r     <= cfg_wdata[LON_W-1:0];
        REG_REQ_LANG:  req_lang_r <= cfg_wdata[LANG_W-1:0];
        REG_REQ_INS:   req_ins_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lat1_c = qlat_r;
    if (qlat_r > LAT_LIMIT) lat1_c = LAT_LIMIT;
    if (qlat_r < -LAT_LIMIT) lat1_c = -LAT_LIMIT;
    lat2_c = in_data.cand_lat;
    if (in_data.cand_lat > LAT_LIMIT) lat2_c = LAT_LIMIT;
    if (in_data.cand_lat < -LAT_LIMIT) lat2_c = -LAT_LIMIT;
  end

  assign dlat_w = {lat2_r[LAT_W-1], lat2_r} - {lat1_r[LAT_W-1], lat1_r};
  assign dl0    = {{2{lon2_r[LON_W-1]}}, lon2_r} - {{2{qlon_r[LON_W-1]}}, qlon_r};

  always_comb begin
    dl1 = dl0;
    if (dl0 >= LON_HALF) dl1 = dl0 - LON_FULL;
    else if (dl0 < -LON_HALF) dl1 = dl0 + LON_FULL;
  end

  always_comb begin
    unique case (cmd.sel)
      2'd0: rad_v = {{2{lat1_r[LAT_W-1]}}, lat1_r};
      2'd1: rad_v = {{2{lat2_r[LAT_W-1]}}, lat2_r};
      2'd2: rad_v = {dlat_r[31], dlat_r};
      2'd3: rad_v = {dlon_r[31], dlon_r};
      default: rad_v = '0;
    endcase
    unique case (cmd.sel)
      2'd0: begin mp = shlat_r; mq = shlat_r; end
      2'd1: begin mp = c1_r;    mq = c2_r;    end
      2'd2: begin mp = shlon_r; mq = shlon_r; end
      2'd3: begin mp = t_r;     mq = u_r;     end
      default: begin mp = '0; mq = '0; end
    endcase
  end

  assign mp_abs = mp[32] ? 33'(-mp) : 33'(mp);
  assign mq_abs = mq[32] ? 33'(-mq) : 33'(mq);
  assign zc     = c_z[ZW-1] ? 33'd0 : c_z[32:0];

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (cmd.op)
      OP_RAD: begin
        mul_a   = RAD_MUL;
        mul_b   = rad_v[32] ? 32'(-rad_v) : 32'(rad_v);
        mul_neg = rad_v[32];
      end
      OP_MUL: begin
        mul_a   = mp_abs;
        mul_b   = mq_abs[31:0];
        mul_neg = mp[32] ^ mq[32];
      end
      OP_DIST: begin
        mul_a = zc;
        mul_b = TWO_R;
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rnd32 = (prod_r + (PROD_W'(1) << 31)) >> 32;
  assign rnd33 = (prod_r + (PROD_W'(1) << 32)) >> 33;
  assign rnd30 = (prod_r + (PROD_W'(1) << 29)) >> 30;
  assign rmag  = half_r ? rnd33[31:0] : rnd32[31:0];
  assign theta = neg_r ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
  assign mr    = neg_r ? -$signed({1'b0, rnd30[32:0]}) : $signed({1'b0, rnd30[32:0]});
  assign asum  = {a_r[33], a_r} + {mr[33], mr};
  assign amag  = a_r[30:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        lat1_r  <= lat1_c;
        lat2_r  <= lat2_c;
        lon2_r  <= in_data.cand_lon;
        match_r <= (in_data.cand_language == req_lang_r) &&
                   (in_data.cand_insurance == req_ins_r);
        last_r  <= in_data.last_item;
        skip_r  <= (count_r == CNT_W'(MAX_CANDIDATES));
      end
      OP_PREP: begin
        dlat_r <= dlat_w;
        dlon_r <= dl1[31:0];
      end
      OP_RAD, OP_MUL, OP_DIST: begin
        prod_r <= mul_p;
        neg_r  <= mul_neg;
        half_r <= cmd.sel[1];
      end
      OP_RSTORE: begin
        unique case (cmd.sel)
          2'd0: c1_r    <= c_x[VW-1:0];
          2'd1: c2_r    <= c_x[VW-1:0];
          2'd2: shlat_r <= c_y[VW-1:0];
          2'd3: shlon_r <= c_y[VW-1:0];
          default: ;
        endcase
      end
      OP_MULW: begin
        unique case (cmd.sel)
          2'd0: a_r <= mr;
          2'd1: t_r <= mr[VW-1:0];
          2'd2: u_r <= mr[VW-1:0];
          2'd3: begin
            if (asum < 0) a_r <= '0;
            else if (asum > Q_ONE_S) a_r <= 34'(Q_ONE);
            else a_r <= asum[33:0];
          end
          default: ;
        endcase
      end
      OP_DISTW: begin
        dist_r <= (rnd30 > PROD_W'(DIST_SAT)) ? DIST_SAT : rnd30[DIST_W-1:0];
      end
      default: ;
    endcase
  end

  assign c_start = (cmd.op == OP_RADW) || (cmd.op == OP_VES);
  assign c_vec   = (cmd.op == OP_VES);
  assign c_xin   = c_vec ? CQ_W'(sb) : CORDIC_X0;
  assign c_yin   = c_vec ? CQ_W'(sa) : '0;
  assign c_zin   = c_vec ? '0 : theta;
  assign s_start = (cmd.op == OP_SQS);

  fngc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (c_start),
    .vec_mode (c_vec),
    .x_in     (c_xin),
    .y_in     (c_yin),
    .z_in     (c_zin),
    .busy     (c_busy),
    .x_out    (c_x),
    .y_out    (c_y),
    .z_out    (c_z)
  );

  fngc_isqrt u_sqrt_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (s_start),
    .v_in  ({1'b0, amag, 30'b0}),
    .busy  (s0_busy),
    .root  (sa)
  );

  fngc_isqrt u_sqrt_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (s_start),
    .v_in  ({1'b0, Q_ONE - amag, 30'b0}),
    .busy  (s1_busy),
    .root  (sb)
  );

  always_comb begin
    count_nxt     = count_r;
    min_idx_nxt   = min_idx_r;
    min_dist_nxt  = min_dist_r;
    any_nxt       = any_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    hit           = !skip_r && match_r && (dist_r < min_dist_r);
    if (cmd.op == OP_UPD) begin
      if (hit) begin
        min_dist_nxt = dist_r;
        min_idx_nxt  = count_r;
        any_nxt      = 1'b1;
      end
      if (!skip_r) begin
        count_nxt = count_r + 1'b1;
      end
      if (last_r) begin
        out_valid_nxt       = 1'b1;
        out_nxt.found       = any_nxt;
        out_nxt.best_idx    = any_nxt ? IDX_W'(min_idx_nxt) : '0;
        out_nxt.best_dist_m = any_nxt ? min_dist_nxt : '0;
        count_nxt           = '0;
        min_idx_nxt         = '0;
        min_dist_nxt        = DIST_ONES;
        any_nxt             = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_idx_r   <= '0;
      min_dist_r  <= DIST_ONES;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      min_idx_r   <= min_idx_nxt;
      min_dist_r  <= min_dist_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign stat.skip  = skip_r;
  assign stat.cbusy = c_busy;
  assign stat.sbusy = s0_busy || s1_busy;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

endmodule

@@ hw/rtl/fngc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fngc_ctrl
// Sequencer that steps the datapath through one candidate distance.
// ----------------------------------------------------------------------------
module fngc_ctrl import fngc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_RAD   = 14'b00000000000100,
    S_RADW  = 14'b00000000001000,
    S_ROT   = 14'b00000000010000,
    S_MUL   = 14'b00000000100000,
    S_MULW  = 14'b00000001000000,
    S_SQS   = 14'b00000010000000,
    S_SQW   = 14'b00000100000000,
    S_VES   = 14'b00001000000000,
    S_VEC   = 14'b00010000000000,
    S_DIST  = 14'b00100000000000,
    S_DISTW = 14'b01000000000000,
    S_UPD   = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd.op    = OP_NOP;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        sel_nxt   = '0;
        state_nxt = stat.skip ? S_UPD : S_RAD;
      end
      S_RAD: begin
        cmd.op    = OP_RAD;
        state_nxt = S_RADW;
      end
      S_RADW: begin
        cmd.op    = OP_RADW;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (!stat.cbusy) begin
          cmd.op  = OP_RSTORE;
          sel_nxt = sel_r + 1'b1;
          state_nxt = (sel_r == 2'd3) ? S_MUL : S_RAD;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        cmd.op    = OP_MULW;
        sel_nxt   = sel_r + 1'b1;
        state_nxt = (sel_r == 2'd3) ? S_SQS : S_MUL;
      end
      S_SQS: begin
        cmd.op    = OP_SQS;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (!stat.sbusy) state_nxt = S_VES;
      end
      S_VES: begin
        cmd.op    = OP_VES;
        state_nxt = S_VEC;
      end
      S_VEC: begin
        if (!stat.cbusy) state_nxt = S_DIST;
      end
      S_DIST: begin
        cmd.op    = OP_DIST;
        state_nxt = S_DISTW;
      end
      S_DISTW: begin
        cmd.op    = OP_DISTW;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op    = OP_UPD;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ tb/filtered_nearest_great_circle_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_nearest_great_circle_top_tb
// Self-checking bench for the filtered nearest great-circle search.
//
// Candidate sets are sent through the start/busy port, and a bit-exact
// fixed-point haversine predictor tracks the nearest matching candidate. Each
// set result seen on out_valid is compared field by field with the oldest
// queued expectation. The bench covers directed corners, register sweeps, an
// oversized set and random sets under three sender idle profiles.
// ----------------------------------------------------------------------------
module filtered_nearest_great_circle_top_tb;
  import fngc_pkg::*;

  localparam int    MAX_CAND    = 1024;
  localparam int    STEPS       = 30;
  localparam int    BUSY_CYCLES = 5 * STEPS + 60;
  localparam longint CYCLE_LIMIT = 3000000;

  localparam longint unsigned RAD_K   = 64'd8048910509;
  localparam longint          X_INIT  = 652032874;
  localparam longint          ONE_Q   = 64'd1 << 30;
  localparam longint          R2      = 12742000;
  localparam longint          SAT_M   = 20037509;
  localparam longint          LATMAX  = 900000000;
  localparam longint          LONHALF = 1800000000;
  localparam longint          LONFULL = 64'sd3600000000;

  localparam longint ARCTAN_Q [0:30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              start;
  logic              busy;
  in_t               in_data;
  logic              out_valid;
  out_t              out_data;

  filtered_nearest_great_circle_top #(
    .MAX_CANDIDATES(MAX_CAND),
    .CORDIC_STEPS  (STEPS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // shadow registers and search state
  longint     q_lat, q_lon;
  logic [2:0] want_lang;
  logic       want_ins;
  longint     near_dist;
  int         near_idx;
  bit         near_any;
  int         cand_count;

  out_t   pending_results[$];
  int     mismatches;
  longint cycles;
  int     send_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint to_rad_q(longint v, int sh);
    longint unsigned u, p;
    u = (v < 0) ? longint'(-v) : longint'(v);
    p = (u * RAD_K + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint unsigned ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p  = (ua * ub + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void rotate_q(longint theta, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = X_INIT;
    y = 0;
    z = theta;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN_Q[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN_Q[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint vector_angle_q(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ARCTAN_Q[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ARCTAN_Q[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_lat(longint v);
    if (v > LATMAX) return LATMAX;
    if (v < -LATMAX) return -LATMAX;
    return v;
  endfunction

  function automatic longint haversine_m(longint lat1, longint lon1, longint lat2,
                                         longint lon2);
    longint dlat, dlon, s1, c1, s2, c2, sh, ch, a, z;
    longint unsigned sa, sb, d;
    lat1 = clamp_lat(lat1);
    lat2 = clamp_lat(lat2);
    dlat = lat2 - lat1;
    dlon = (lon2 - lon1) % LONFULL;
    if (dlon < -LONHALF) dlon = dlon + LONFULL;
    if (dlon >= LONHALF) dlon = dlon - LONFULL;
    rotate_q(to_rad_q(lat1, 32), s1, c1);
    rotate_q(to_rad_q(lat2, 32), s2, c2);
    rotate_q(to_rad_q(dlat, 33), sh, ch);
    a = mul_q(sh, sh);
    rotate_q(to_rad_q(dlon, 33), sh, ch);
    a = a + mul_q(mul_q(c1, c2), mul_q(sh, sh));
    if (a < 0) a = 0;
    if (a > ONE_Q) a = ONE_Q;
    sa = root_floor(longint'(a) << 30);
    sb = root_floor(longint'(ONE_Q - a) << 30);
    z  = vector_angle_q(longint'(sa), longint'(sb));
    if (z < 0) z = 0;
    d = (longint'(z) * R2 + (64'd1 << 29)) >> 30;
    if (d > SAT_M) d = SAT_M;
    return longint'(d);
  endfunction

  function automatic void clear_search();
    near_dist  = 64'h1FFFFFF;
    near_idx   = 0;
    near_any   = 0;
    cand_count = 0;
  endfunction

  function automatic void track_candidate(in_t c);
    longint d;
    out_t   r;
    if (cand_count < MAX_CAND) begin
      d = haversine_m(q_lat, q_lon, longint'($signed(c.cand_lat)),
                      longint'($signed(c.cand_lon)));
      if (c.cand_language == want_lang && c.cand_insurance == want_ins &&
          d < near_dist) begin
        near_dist = d;
        near_idx  = cand_count;
        near_any  = 1;
      end
      cand_count++;
    end
    if (c.last_item) begin
      r.found       = near_any;
      r.best_idx    = near_any ? IDX_W'(near_idx) : '0;
      r.best_dist_m = near_any ? DIST_W'(near_dist) : '0;
      pending_results = {pending_results, r};
      clear_search();
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d idx=%0d dist=%0d",
                   out_data.found, out_data.best_idx, out_data.best_dist_m);
      end else begin
        out_t e;
        e = pending_results.pop_front();
        if (e.found !== out_data.found || e.best_idx !== out_data.best_idx ||
            e.best_dist_m !== out_data.best_dist_m) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0d idx=%0d dist=%0d, got %0d %0d %0d",
                     e.found, e.best_idx, e.best_dist_m, out_data.found,
                     out_data.best_idx, out_data.best_dist_m);
        end
      end
    end
  end

  // call at a falling edge; returns at a falling edge
  task automatic send_candidate(in_t c);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(1, 12)) @(negedge clk);
    start   = 1'b1;
    in_data = c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    track_candidate(c);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_point(longint lat, longint lon, int lang, int ins, bit last);
    in_t c;
    c.cand_lat       = LAT_W'(lat);
    c.cand_lon       = LON_W'(lon);
    c.cand_language  = LANG_W'(lang);
    c.cand_insurance = ins[0];
    c.last_item      = last;
    send_candidate(c);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, longint value);
    drain();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = CFG_DW'(value);
    case (idx)
      REG_QUERY_LAT: q_lat = longint'($signed(cfg_wdata[LAT_W-1:0]));
      REG_QUERY_LON: q_lon = longint'($signed(cfg_wdata));
      REG_REQ_LANG:  want_lang = cfg_wdata[2:0];
      REG_REQ_INS:   want_ins = cfg_wdata[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_directed();
    // default query, filters 0/0
    send_point(LATMAX, LONHALF, 0, 0, 0);
    send_point(-LATMAX, -LONHALF, 0, 0, 0);
    send_point(423601000, -710589000, 0, 0, 0);
    send_point(423601000, -710589000, 0, 0, 1);
    // out-of-range latitude and wrapped longitude
    send_point(1073741823, 2147483647, 0, 0, 0);
    send_point(-1073741824, -2147483648, 0, 0, 1);
    // no match
    send_point(0, 0, 7, 0, 0);
    send_point(0, 0, 0, 1, 1);
    // antipode, the farthest point
    send_point(-423601000, 1089411000, 0, 0, 1);
    // tie, earliest wins
    send_point(100000000, 200000000, 3, 0, 0);
    send_point(100000000, 200000000, 0, 0, 0);
    send_point(100000000, 200000000, 0, 0, 1);
    // single candidate set
    send_point(0, 0, 0, 0, 1);
    drain();
    write_reg(REG_QUERY_LAT, LATMAX);
    write_reg(REG_QUERY_LON, LONHALF);
    write_reg(REG_REQ_LANG, 7);
    write_reg(REG_REQ_INS, 1);
    send_point(LATMAX, -LONHALF, 7, 1, 0);
    send_point(-LATMAX, 0, 7, 1, 0);
    send_point(0, LONHALF - 1, 7, 1, 1);
    write_reg(REG_QUERY_LAT, -LATMAX);
    write_reg(REG_QUERY_LON, -LONHALF);
    send_point(LATMAX, LONHALF, 7, 1, 0);
    send_point(-LATMAX, 5, 7, 1, 1);
  endtask

  task automatic test_oversized_set();
    write_reg(REG_QUERY_LAT, 0);
    write_reg(REG_QUERY_LON, 0);
    write_reg(REG_REQ_LANG, 2);
    write_reg(REG_REQ_INS, 0);
    for (int i = 0; i < MAX_CAND + 6; i++) begin
      if (i >= MAX_CAND - 2)
        send_point(0, 0, 2, 0, i == MAX_CAND + 5);
      else
        send_point($urandom_range(0, 1800000000) - 900000000,
                   $urandom_range(0, 3600000000) - 1800000000,
                   $urandom_range(0, 7), $urandom_range(0, 1), 0);
    end
  endtask

  task automatic random_config();
    write_reg(REG_QUERY_LAT, $urandom_range(0, 1800000000) - 900000000);
    write_reg(REG_QUERY_LON, longint'($urandom_range(0, 3600000000)) - 1800000000);
    write_reg(REG_REQ_LANG, $urandom_range(0, 7));
    write_reg(REG_REQ_INS, $urandom_range(0, 1));
  endtask

  task automatic random_sets(int count);
    int sent, len, mode;
    in_t c, prev;
    sent = 0;
    prev = '0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) random_config();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
          c.cand_lat = LAT_W'($urandom());
          c.cand_lon = LON_W'($urandom());
        end else if (mode < 4) begin
          c.cand_lat = LAT_W'(q_lat + $urandom_range(0, 2000000) - 1000000);
          c.cand_lon = LON_W'(q_lon + $urandom_range(0, 2000000) - 1000000);
        end else if (mode == 4 && i > 0) begin
          c = prev;
        end else begin
          c.cand_lat = LAT_W'($urandom_range(0, 1800000000) - 900000000);
          c.cand_lon = LON_W'(longint'($urandom_range(0, 3600000000)) - 1800000000);
        end
        c.cand_language  = ($urandom_range(0, 1)) ? want_lang : LANG_W'($urandom());
        c.cand_insurance = ($urandom_range(0, 3) != 0) ? want_ins : 1'($urandom());
        c.last_item      = (i == len - 1);
        prev = c;
        send_candidate(c);
        sent++;
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 34;
    random_sets(270);
    send_idle_pct = 80;
    random_sets(270);
    send_idle_pct = 0;
    random_sets(270);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    start         = 1'b0;
    in_data       = '0;
    cycles        = 0;
    mismatches    = 0;
    send_idle_pct = 0;
    q_lat         = 423601000;
    q_lon         = -710589000;
    want_lang     = 3'd0;
    want_ins      = 1'b0;
    clear_search();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    test_directed();
    test_oversized_set();
    test_random_phases();

    drain();
    repeat (BUSY_CYCLES + 20) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
